// ===== sv/fir_q16_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_q16_pkg: shared types and constants for the Q16 rounding FIR filter
// Widths, command codes and the token that runs down the tap chain.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_q16_pkg;

  // Field widths
  localparam int unsigned DataW = 16;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned AccW  = 32;

  // Default tap count
  localparam int unsigned TapsDefault = 32;

  // Rounding offset added before the Q16 shift
  localparam logic [AccW-1:0] RoundConst = 32'h0000_8000;

  // Item commands
  typedef enum logic {
    CMD_COEFF  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // Partial sum travelling from cell to cell
  typedef struct packed {
    logic            vld;
    logic [AccW-1:0] psum;
  } fir_q16_tok_t;

endpackage : fir_q16_pkg

`default_nettype wire

// ===== sv/fir_filter_q16_round.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q16_round: streaming FIR filter with Q16 rounding
// Direct-form filter built as a row of tap cells. A sample item shifts the
// delay line; a partial sum then walks the cells, one tap per cycle.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                       | direction
//  ---------+-----------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, cmd_i, coeff_index_i, | sink
//           | data_value_i                                  |
//  out      | out_valid_o, out_ready_i, filtered_sample_o   | source
//
//  A coefficient item is written in its accept cycle and gives no result.
//  A sample item shifts the delay line at accept; the sum then runs through
//  the Taps cells, one per cycle, and then enters the output register.
//  One sample is in the chain at a time, from accept to the output register.
//  Reset clears delay line and coefficients to zero.
//  A stalled output holds the finished sum in the last cell; the next item
//  is taken as soon as the output register has it.
//
`default_nettype none

module fir_filter_q16_round import fir_q16_pkg::*; #(
  parameter int unsigned Taps = TapsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             cmd_i,
  input  wire logic [IdxW-1:0]  coeff_index_i,
  input  wire logic [DataW-1:0] data_value_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [DataW-1:0] filtered_sample_o
);

  logic busy_q, start_q, out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic in_acc, push_acc, coeff_acc, en, out_load, last_vld;

  fir_q16_tok_t     tok_w    [Taps+1];
  logic [DataW-1:0] sample_w [Taps+1];

  // Handshake and chain control
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign push_acc   = in_acc && (cmd_i == CMD_SAMPLE);
  assign coeff_acc  = in_acc && (cmd_i == CMD_COEFF);
  assign last_vld   = tok_w[Taps].vld;
  assign out_load   = last_vld && (!out_valid_q || out_ready_i);
  assign en         = !(last_vld && !out_load);

  // Chain head: rounding offset enters with the token
  assign tok_w[0] = '{vld: start_q, psum: RoundConst};
  assign sample_w[Taps] = data_value_i;

  // Row of tap cells
  for (genvar j = 0; j < Taps; j++) begin : g_cell
    logic we;
    assign we = coeff_acc && (32'(coeff_index_i) == j);

    fir_q16_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .shift_i    (push_acc),
      .sample_i   (sample_w[j+1]),
      .sample_o   (sample_w[j]),
      .coeff_we_i (we),
      .coeff_i    (data_value_i),
      .tok_i      (tok_w[j]),
      .tok_o      (tok_w[j+1])
    );
  end

  // Busy from sample accept until the sum reaches the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= push_acc;
      if (push_acc) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register: bits 31..16 of the rounded sum
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= tok_w[Taps].psum[AccW-1:AccW-DataW];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;

endmodule : fir_filter_q16_round

`default_nettype wire

// ===== sv/fir_q16_cell.sv =====
// ----------------------------------------------------------------------------
// fir_q16_cell: one tap of the FIR chain
// Holds one delay-line sample and one coefficient. Adds its product to the
// partial sum handed in by the left neighbor and passes it on, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_q16_cell import fir_q16_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             shift_i,
  input  wire logic [DataW-1:0] sample_i,
  output logic      [DataW-1:0] sample_o,
  input  wire logic             coeff_we_i,
  input  wire logic [DataW-1:0] coeff_i,
  input  wire fir_q16_tok_t     tok_i,
  output fir_q16_tok_t          tok_o
);

  logic [DataW-1:0] sample_q, coeff_q;
  fir_q16_tok_t     tok_d;
  logic             vld_q;
  logic [AccW-1:0]  psum_q;
  logic signed [AccW-1:0] prod;

  // Delay-line sample and coefficient storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      coeff_q  <= '0;
    end else begin
      if (shift_i) begin
        sample_q <= sample_i;
      end
      if (coeff_we_i) begin
        coeff_q <= coeff_i;
      end
    end
  end

  // Multiply-accumulate on the passing token
  assign prod = AccW'($signed(coeff_q) * $signed(sample_q));

  always_comb begin
    tok_d.vld  = tok_i.vld;
    tok_d.psum = tok_i.psum + prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && tok_d.vld) begin
      psum_q <= tok_d.psum;
    end
  end

  assign sample_o = sample_q;

  // Token handed to the right neighbor
  always_comb begin
    tok_o.vld  = vld_q;
    tok_o.psum = psum_q;
  end

endmodule : fir_q16_cell

`default_nettype wire

// ===== test/fir_filter_q16_round_tb.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q16_round_tb: self-checking bench for the Q16 rounding FIR filter
// Coefficient and sample items are fed with random bursts and gaps while the
// output side stalls on its own pattern. A local model of the tap window and
// the coefficients predicts each filtered sample, checked in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_q16_round_tb;
  import fir_q16_pkg::*;

  localparam int unsigned Taps       = TapsDefault;
  localparam int          NumRandom  = 800;
  localparam int          CycleLimit = 500000;
  localparam int          MaxReports = 10;

  // One input item plus a flag that holds it back until the output drains
  typedef struct {
    cmd_e             cmd;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] value;
    bit               drain;
  } filter_item_t;

  // DUT connections, known from time zero
  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic             cmd_i            = CMD_SAMPLE;
  logic [IdxW-1:0]  coeff_index_i    = '0;
  logic [DataW-1:0] data_value_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  logic [DataW-1:0] filtered_sample_o;

  // Bench state
  filter_item_t     item_q[$];
  filter_item_t     cur_item;
  logic [DataW-1:0] want_sample_q[$];
  int               n_pushed   = 0;
  int               n_checked  = 0;
  int               errors     = 0;
  int               mismatches = 0;
  int               cycles     = 0;
  int               burst_left = 0;
  int               gap_left   = 0;
  int               ready_run  = 0;
  int               pushed_now;
  logic [DataW-1:0] want;

  // Model copy of the filter state
  logic signed [DataW-1:0] tap_coef [Taps];
  logic signed [DataW-1:0] window   [Taps];

  fir_filter_q16_round #(
    .Taps(Taps)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .coeff_index_i    (coeff_index_i),
    .data_value_i     (data_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_sample_o(filtered_sample_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one accepted item to the model; a sample yields one expected output
  task automatic filter_apply(input filter_item_t it);
    logic [AccW-1:0]        acc;
    logic signed [AccW-1:0] prod;
    acc = '0;
    if (it.cmd == CMD_COEFF) begin
      if (it.idx < Taps) tap_coef[it.idx] = it.value;
    end else begin
      for (int j = 0; j < Taps - 1; j++) window[j] = window[j+1];
      window[Taps-1] = it.value;
      // 32-bit wrap matches the kept bits of a wider sum
      for (int j = 0; j < Taps; j++) begin
        prod = tap_coef[j] * window[j];
        acc  = acc + prod;
      end
      acc = acc + RoundConst;
      want_sample_q.push_back(acc[AccW-1:16]);
    end
  endtask

  task automatic add_item(input cmd_e cmd, input int idx, input int value, input bit drain);
    filter_item_t it;
    it.cmd   = cmd;
    it.idx   = idx[IdxW-1:0];
    it.value = value[DataW-1:0];
    it.drain = drain;
    item_q.push_back(it);
  endtask

  // Random item: mostly samples, with extremes mixed in
  function automatic filter_item_t rand_item();
    filter_item_t it;
    it.cmd   = ($urandom_range(0, 3) == 0) ? CMD_COEFF : CMD_SAMPLE;
    it.idx   = IdxW'($urandom);
    it.drain = 1'b0;
    case ($urandom_range(0, 9))
      0:       it.value = 16'h8000;
      1:       it.value = 16'h7fff;
      2:       it.value = 16'hffff;
      3:       it.value = DataW'($urandom_range(0, 255));
      default: it.value = DataW'($urandom);
    endcase
    return it;
  endfunction

  // Input driver: bursts and gaps, hold-off on drain items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      pushed_now = n_pushed;
      if (in_valid_i && in_ready_o) begin
        filter_apply(cur_item);
        if (cur_item.cmd == CMD_SAMPLE) begin
          pushed_now = n_pushed + 1;
          n_pushed   <= n_pushed + 1;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (item_q.size() != 0 &&
                     !(item_q[0].drain && pushed_now != n_checked)) begin
          cur_item = item_q.pop_front();
          in_valid_i    <= 1'b1;
          cmd_i         <= cur_item.cmd;
          coeff_index_i <= cur_item.idx;
          data_value_i  <= cur_item.value;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45)
                                                     : $urandom_range(0, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (n_pushed == n_checked) begin
          errors++;
          if (mismatches < MaxReports)
            $display("unexpected output item: got %0d", $signed(filtered_sample_o));
          mismatches++;
        end else begin
          want = want_sample_q.pop_front();
          n_checked <= n_checked + 1;
          if (filtered_sample_o !== want) begin
            errors++;
            if (mismatches < MaxReports)
              $display("filtered_sample mismatch #%0d: expected %0d, actual %0d",
                       n_checked, $signed(want), $signed(filtered_sample_o));
            mismatches++;
          end
        end
      end
      if (ready_run > 0) begin
        ready_run--;
      end else if ($urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
        ready_run = $urandom_range(1, 60);
      end else begin
        out_ready_i <= 1'b0;
        ready_run = $urandom_range(1, 40);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j < Taps; j++) begin
      tap_coef[j] = '0;
      window[j]   = '0;
    end

    // Directed: zero coefficients after reset, field extremes, accumulator wrap
    add_item(CMD_SAMPLE, 0,  32767,  1'b0);
    add_item(CMD_COEFF,  31, 32767,  1'b0);
    add_item(CMD_SAMPLE, 31, -32768, 1'b0);
    add_item(CMD_COEFF,  0,  -32768, 1'b0);
    add_item(CMD_SAMPLE, 0,  -1,     1'b0);
    // three full-scale products overflow the signed 32-bit range
    add_item(CMD_COEFF,  29, -32768, 1'b0);
    add_item(CMD_COEFF,  30, -32768, 1'b0);
    add_item(CMD_COEFF,  31, -32768, 1'b0);
    add_item(CMD_SAMPLE, 5,  -32768, 1'b0);
    add_item(CMD_SAMPLE, 10, -32768, 1'b0);
    add_item(CMD_SAMPLE, 21, -32768, 1'b0);
    add_item(CMD_SAMPLE, 0,  0,      1'b1);
    add_item(CMD_COEFF,  15, 1,      1'b0);
    add_item(CMD_SAMPLE, 0,  1,      1'b0);
    add_item(CMD_SAMPLE, 0,  32767,  1'b0);
    add_item(CMD_COEFF,  16'h15, 16'h5555, 1'b0);
    add_item(CMD_COEFF,  16'h0a, 16'haaaa, 1'b0);
    add_item(CMD_SAMPLE, 16'h0a, 16'h5555, 1'b0);
    add_item(CMD_SAMPLE, 16'h15, 16'haaaa, 1'b0);

    // Random part, with two drain points
    for (int n = 0; n < NumRandom; n++) begin
      item_q.push_back(rand_item());
      if (n == 250 || n == 600) item_q[item_q.size()-1].drain = 1'b1;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for all items taken, all results in, then let the chain settle
    while (item_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (n_pushed != n_checked) @(negedge clk_i);
    repeat (Taps + 8) @(negedge clk_i);

    if (want_sample_q.size() != 0) begin
      $display("%0d expected outputs never arrived", want_sample_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : fir_filter_q16_round_tb

`default_nettype wire

// ===== fir_filter_q16_round.f =====
sv/fir_q16_pkg.sv
sv/fir_q16_cell.sv
sv/fir_filter_q16_round.sv
test/fir_filter_q16_round_tb.sv
